// ----- sv/lcss_pkg.sv -----
// Shared types and constants for the line centroid steering block.
package lcss_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int POS_W      = 7;
    localparam int SUM_W      = 13;
    localparam int CNT_W      = 7;
    localparam int SPEED_W    = 8;
    localparam int DUTY_W     = 7;
    localparam int PROD_W     = 13;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CENTER_SH  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [POS_W-1:0]    POS_MAX     = 7'd127;
    localparam logic [POS_W-1:0]    CENTER_POS  = 7'd64;
    localparam int                  PIXELS_USED_DEF = 127;

    localparam logic [SAMPLE_W-1:0] THRESH_RST = 12'd2000;
    localparam logic [DUTY_W-1:0]   BASE_RST   = 7'd30;
    localparam logic [DUTY_W-1:0]   SPAN_RST   = 7'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } lcss_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   turn_position;
        logic [SPEED_W-1:0] drive_speed;
        logic               stop;
    } lcss_out_t;

    // One finished scan line as handed from the accumulator to the solver
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } lcss_line_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lcss_q_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_EMIT
    } lcss_bk_state_t;

endpackage

// ----- sv/lcss_front.sv -----
// Pixel accumulator: thresholds samples and sums line pixel positions.
module lcss_front #(
    parameter int PIXELS_USED = lcss_pkg::PIXELS_USED_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [lcss_pkg::SAMPLE_W-1:0]      threshold,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lcss_pkg::lcss_in_t                 s_data,
    input  lcss_pkg::lcss_q_stat_t             q_stat,
    output logic                               push,
    output lcss_pkg::lcss_line_t               push_data
);
    import lcss_pkg::*;

    localparam logic [POS_W-1:0] USED_LIMIT = POS_W'(PIXELS_USED);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hit;
    logic             accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign hit     = (pos_reg < USED_LIMIT) && (s_data.sample >= threshold);

    assign push           = accept && s_data.line_end;
    assign push_data.sum   = sum_reg + (hit ? SUM_W'(pos_reg) : '0);
    assign push_data.count = cnt_reg + CNT_W'(hit);

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (accept) begin
            if (s_data.line_end) begin
                sum_next = '0;
                cnt_next = '0;
                pos_next = '0;
            end else begin
                sum_next = push_data.sum;
                cnt_next = push_data.count;
                // saturate on overlong lines
                if (pos_reg < POS_MAX) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- sv/lcss_queue.sv -----
// Two-entry queue of finished scan lines between accumulator and solver.
module lcss_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lcss_pkg::lcss_line_t   push_data,
    input  logic                   pop,
    output lcss_pkg::lcss_line_t   pop_data,
    output lcss_pkg::lcss_q_stat_t q_stat
);
    import lcss_pkg::*;

    lcss_line_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- sv/lcss_back.sv -----
// Line solver: serial centroid divide, speed from distance to center, result register.
module lcss_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lcss_pkg::DUTY_W-1:0]   base_speed,
    input  logic [lcss_pkg::DUTY_W-1:0]   speed_span,
    input  lcss_pkg::lcss_q_stat_t        q_stat,
    input  lcss_pkg::lcss_line_t          pop_data,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lcss_pkg::lcss_out_t           m_data
);
    import lcss_pkg::*;

    lcss_bk_state_t state_reg, state_next;

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     div_reg;
    logic                 zero_reg;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]     turn_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 out_valid_reg, out_valid_next;
    lcss_out_t            out_reg;

    logic [CNT_W:0]       trial;
    logic                 ge;
    logic [POS_W-1:0]     turn;
    logic [POS_W-1:0]     center_off;
    logic [PROD_W:0]      round_sum;
    logic [SPEED_W-1:0]   drop;
    logic [SPEED_W-1:0]   full;
    logic [SPEED_W-1:0]   speed;
    logic                 out_free;
    logic                 load, div_step, mul_load, emit;

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_DIV;
            BK_DIV:  if (step_reg == '0) state_next = BK_MUL;
            BK_MUL:  state_next = BK_EMIT;
            BK_EMIT: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        load     = 1'b0;
        div_step = 1'b0;
        mul_load = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            BK_IDLE: load     = !q_stat.empty;
            BK_DIV:  div_step = 1'b1;
            BK_MUL:  mul_load = 1'b1;
            BK_EMIT: emit     = out_free;
            default: ;
        endcase
    end

    assign pop = load;

    // one restoring divide step per cycle, quotient shifts into the dividend
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (load) begin
            quo_next  = pop_data.sum;
            rem_next  = '0;
            step_next = DIV_CNT_W'(SUM_W - 1);
        end else if (div_step) begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
            step_next = step_reg - DIV_CNT_W'(1);
        end
    end

    assign turn       = zero_reg ? '0 : quo_reg[POS_W-1:0];
    assign center_off = (turn >= CENTER_POS) ? (turn - CENTER_POS) : (CENTER_POS - turn);

    // drop = ceil(span * center_off / 64)
    assign round_sum = {1'b0, prod_reg} + (PROD_W+1)'((1 << CENTER_SH) - 1);
    assign drop      = SPEED_W'(round_sum >> CENTER_SH);
    assign full      = SPEED_W'(base_speed) + SPEED_W'(speed_span);
    assign speed     = (drop >= full) ? '0 : (full - drop);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (load) begin
            div_reg  <= pop_data.count;
            zero_reg <= (pop_data.count == '0);
        end
        if (mul_load) begin
            turn_reg <= turn;
            prod_reg <= PROD_W'(speed_span) * PROD_W'(center_off);
        end
        if (emit) begin
            out_reg.turn_position <= turn_reg;
            out_reg.drive_speed   <= (turn_reg == '0) ? '0 : speed;
            out_reg.stop          <= (turn_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- sv/line_centroid_steer_speed.sv -----
// Top level of the line centroid tracker with steering and speed output.
//
//  port group   dir  handshake          payload
//  cfg_*        in   cfg_we (no wait)   cfg_index, cfg_data
//  s_*          in   s_valid / s_ready  sample, line_end
//  m_*          out  m_valid / m_ready  turn_position, drive_speed, stop
//
// Pixels are taken one per cycle; s_ready falls only while two finished
// lines wait in the queue ahead of the solver.
// Each line passes through the solver as one load, 13 divide steps, one
// multiply and one result write, so lines of 16 pixels or more keep the
// input at full rate when the result side does not stall.
// A stalled result holds in the output register while the next line
// divides. Reset restores the register defaults and clears the accumulator and queue counters.
module line_centroid_steer_speed #(
    parameter int PIXELS_USED = lcss_pkg::PIXELS_USED_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lcss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lcss_pkg::lcss_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lcss_pkg::lcss_out_t               m_data
);
    import lcss_pkg::*;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [DUTY_W-1:0]   base_reg;
    logic [DUTY_W-1:0]   span_reg;

    lcss_q_stat_t q_stat;
    lcss_line_t   push_data;
    lcss_line_t   pop_data;
    logic         push;
    logic         pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RST;
            base_reg      <= BASE_RST;
            span_reg      <= SPAN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_BASE:      base_reg      <= cfg_data[DUTY_W-1:0];
                CFG_SPAN:      span_reg      <= cfg_data[DUTY_W-1:0];
                default:       ;
            endcase
        end
    end

    lcss_front #(
        .PIXELS_USED (PIXELS_USED)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    lcss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    lcss_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .base_speed (base_reg),
        .speed_span (span_reg),
        .q_stat     (q_stat),
        .pop_data   (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- dv/tb_line_centroid_steer_speed.sv -----
// Self-checking testbench for the line centroid tracker: random lines, config sweeps, stalls.
`timescale 1ns / 100ps

module tb_line_centroid_steer_speed;
    import lcss_pkg::*;

    localparam int USED_PIXELS   = PIXELS_USED_DEF;
    localparam int PHASES        = 6;
    localparam int PHASE_PIXELS  = 100;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT    = 3000;
    localparam int REPORT_MAX    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    lcss_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    lcss_out_t             m_data;

    line_centroid_steer_speed #(
        .PIXELS_USED(USED_PIXELS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Predictor copy of the registers and the line accumulator
    logic [SAMPLE_W-1:0] line_level = THRESH_RST;
    logic [DUTY_W-1:0]   duty_base  = BASE_RST;
    logic [DUTY_W-1:0]   duty_span  = SPAN_RST;
    logic [SUM_W-1:0]    pos_sum    = '0;
    logic [CNT_W-1:0]    hit_cnt    = '0;
    logic [POS_W-1:0]    scan_pos   = '0;

    lcss_in_t  pixel_q[$];
    lcss_out_t steer_due[$];
    int        bad_beats   = 0;
    int        feed_gap    = 0;
    int        take_gap    = 0;
    int        idle_cycles = 0;
    bit        feed_calm   = 1'b0;
    bit        take_calm   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Accumulate one pixel; on the line end compute centroid and speed
    task automatic track_pixel(input lcss_in_t px);
        lcss_out_t res;
        int        turn, center_off, drop, full, ctr;
        if (scan_pos < USED_PIXELS && px.sample >= line_level) begin
            pos_sum = pos_sum + scan_pos;
            hit_cnt = hit_cnt + 1'b1;
        end
        if (scan_pos != POS_MAX)
            scan_pos = scan_pos + 1'b1;
        if (px.line_end) begin
            res.turn_position = (hit_cnt != 0) ? POS_W'(pos_sum / hit_cnt) : '0;
            res.drive_speed   = '0;
            res.stop          = 1'b1;
            if (res.turn_position != 0) begin
                ctr  = int'(CENTER_POS);
                turn = int'(res.turn_position);
                center_off = (turn >= ctr) ? turn - ctr : ctr - turn;
                drop = (int'(duty_span) * center_off + ctr - 1) / ctr;
                full = int'(duty_base) + int'(duty_span);
                res.drive_speed = (drop >= full) ? '0 : SPEED_W'(full - drop);
                res.stop        = 1'b0;
            end
            steer_due.push_back(res);
            pos_sum  = '0;
            hit_cnt  = '0;
            scan_pos = '0;
        end
    endtask

    // Sender: present queued pixels with random gaps between beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (feed_gap != 0) begin
                feed_gap <= feed_gap - 1;
                s_valid  <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_data   <= pixel_q.pop_front();
                s_valid  <= 1'b1;
                feed_gap <= feed_calm ? 0 : $urandom_range(0, 11);
            end else begin
                s_valid <= 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                feed_calm <= !feed_calm;
        end
    end

    // Receiver: predict on accepted pixels, check result beats, stall at random
    always @(posedge aclk) begin
        lcss_out_t want;
        int        hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_pixel(s_data);
            if (m_valid && m_ready) begin
                if (steer_due.size() == 0) begin
                    bad_beats++;
                    if (bad_beats <= REPORT_MAX)
                        $display("unexpected result beat: turn %0d speed %0d stop %0d",
                                 m_data.turn_position, m_data.drive_speed, m_data.stop);
                end else begin
                    want = steer_due.pop_front();
                    if (m_data.turn_position !== want.turn_position ||
                        m_data.drive_speed   !== want.drive_speed ||
                        m_data.stop          !== want.stop) begin
                        bad_beats++;
                        if (bad_beats <= REPORT_MAX) begin
                            $write("result mismatch: expected turn %0d speed %0d stop %0d, ",
                                   want.turn_position, want.drive_speed, want.stop);
                            $display("got turn %0d speed %0d stop %0d",
                                     m_data.turn_position, m_data.drive_speed, m_data.stop);
                        end
                    end
                end
                hold = take_calm ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0)
                    take_calm <= !take_calm;
                m_ready  <= (hold == 0);
                take_gap <= (hold == 0) ? 0 : hold - 1;
            end else if (take_gap != 0) begin
                take_gap <= take_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_pixel(input logic [SAMPLE_W-1:0] smp, input logic last);
        pixel_q.push_back('{sample: smp, line_end: last});
    endtask

    // Write a register at one edge and mirror it into the predictor
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: line_level = val;
            CFG_BASE:      duty_base  = val[DUTY_W-1:0];
            CFG_SPAN:      duty_span  = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every pixel is sent and every result has arrived, then let the solver idle
    task automatic settle();
        do @(posedge aclk);
        while (pixel_q.size() != 0 || s_valid || steer_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One scan line of random content, mostly a bright band on a dark field
    task automatic queue_scan(input int len);
        int                  style, band_lo, band_hi;
        logic [SAMPLE_W-1:0] smp;
        style   = $urandom_range(0, 9);
        band_lo = $urandom_range(0, len - 1);
        band_hi = band_lo + $urandom_range(0, 11);
        for (int i = 0; i < len; i++) begin
            if (style <= 5) begin
                if (i >= band_lo && i <= band_hi)
                    smp = SAMPLE_W'($urandom_range(4095, line_level));
                else
                    smp = (line_level == 0) ? '0 : SAMPLE_W'($urandom_range(line_level - 1, 0));
            end else if (style == 6) begin
                smp = SAMPLE_W'($urandom);
            end else if (style == 7) begin
                smp = (line_level == 0) ? '0 : SAMPLE_W'($urandom_range(line_level - 1, 0));
            end else if (style == 8) begin
                smp = $urandom_range(0, 1) ? line_level : line_level - 1'b1;
            end else begin
                smp = '1;
            end
            queue_pixel(smp, i == len - 1);
        end
    endtask

    initial begin
        int len;
        int queued;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: empty line, hit only at position zero, threshold edge
        queue_pixel(12'd0, 1'b1);
        queue_pixel(12'd4095, 1'b1);
        queue_pixel(12'd1999, 1'b0);
        queue_pixel(12'd2000, 1'b0);
        queue_pixel(12'd1999, 1'b1);
        queue_pixel(12'd0, 1'b0);
        queue_pixel(12'd4095, 1'b0);
        queue_pixel(12'd4095, 1'b0);
        queue_pixel(12'd4095, 1'b1);
        queue_pixel(12'd4095, 1'b0);
        queue_pixel(12'd0, 1'b0);
        queue_pixel(12'd4095, 1'b1);
        settle();

        // Zero threshold and zero duty: every pixel counts, speed collapses to zero
        set_reg(CFG_THRESHOLD, 12'd0);
        set_reg(CFG_BASE, 12'd0);
        set_reg(CFG_SPAN, 12'd0);
        for (int i = 0; i < 4; i++)
            queue_pixel(12'd0, i == 3);
        settle();

        // Full-scale threshold, duty writes beyond range get masked, unused index dropped
        set_reg(CFG_THRESHOLD, 12'hFFF);
        set_reg(CFG_BASE, 12'hFFF);
        set_reg(CFG_SPAN, 12'hFFF);
        set_reg(CFG_UNUSED, 12'h5A5);
        queue_pixel(12'd4094, 1'b0);
        queue_pixel(12'd4095, 1'b0);
        queue_pixel(12'd4095, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1500, 2500)));
                    set_reg(CFG_BASE, CFG_DATA_W'(BASE_RST));
                    set_reg(CFG_SPAN, CFG_DATA_W'(SPAN_RST));
                end
                1: begin
                    set_reg(CFG_THRESHOLD, 12'd0);
                    set_reg(CFG_BASE, 12'd0);
                    set_reg(CFG_SPAN, 12'd0);
                end
                2: begin
                    set_reg(CFG_THRESHOLD, 12'd4095);
                    set_reg(CFG_BASE, 12'd100);
                    set_reg(CFG_SPAN, 12'd100);
                end
                3: begin
                    set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(200, 3900)));
                    set_reg(CFG_BASE, 12'hFFF);
                    set_reg(CFG_SPAN, 12'h07F);
                end
                4: begin
                    set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom));
                    set_reg(CFG_BASE, CFG_DATA_W'($urandom));
                    set_reg(CFG_SPAN, CFG_DATA_W'($urandom));
                end
                default: begin
                    set_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(500, 3500)));
                    set_reg(CFG_BASE, CFG_DATA_W'($urandom_range(0, 100)));
                    set_reg(CFG_SPAN, CFG_DATA_W'($urandom_range(0, 100)));
                end
            endcase
            set_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            queued = 0;
            while (queued < PHASE_PIXELS) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 140)
                                                  : $urandom_range(1, 24);
                queue_scan(len);
                queued += len;
            end
        end

        settle();
        if (bad_beats == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
